@@ rtl/rmq_pkg.sv @@
// package: shared types and constants for the rotation matrix to quaternion unit
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int unsigned FRAC = 16;
  localparam int unsigned DW = 18;
  // argument width: A in [ONE, ONE + 3*2^(DW-1)]
  localparam int unsigned AW = DW + 3;
  // radicand A << FRAC
  localparam int unsigned SW = AW + FRAC;
  // root width
  localparam int unsigned RW = (SW + 1) / 2;
  // numerator magnitude |d| << FRAC
  localparam int unsigned NW = DW + 1 + FRAC;
  // quotient width
  localparam int unsigned QW = NW;
  // number of root cells, one result bit each
  localparam int unsigned NSQ = RW;
  // number of divide cells, one quotient bit each
  localparam int unsigned NDV = QW;

  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  // item carried along the root chain
  typedef struct packed {
    big_t big;
    logic signed [DW:0] d0;
    logic signed [DW:0] d1;
    logic signed [DW:0] d2;
  } side_t;

  // divide chain lane state
  typedef struct packed {
    logic neg;
    logic [NW-1:0] num;
    logic [RW+1:0] rem;
    logic [QW-1:0] quo;
  } dlane_t;

  function automatic logic signed [DW-1:0] sat(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] mx;
    logic signed [QW+1:0] mn;
    mx = (QW+2)'((64'sd1 <<< (DW - 1)) - 64'sd1);
    mn = -(QW+2)'(64'sd1 <<< (DW - 1));
    if (v > mx) return mx[DW-1:0];
    if (v < mn) return mn[DW-1:0];
    return v[DW-1:0];
  endfunction
endpackage

@@ rtl/rmq_sqrt_cell.sv @@
// module: one restoring square root step per cell, registered
`timescale 1ns / 1ps
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vld_in,
  input  logic [SW-1:0] rad_in,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  side_t side_in,
  output logic vld_out,
  output logic [SW-1:0] rad_out,
  output logic [RW+1:0] rem_out,
  output logic [RW-1:0] root_out,
  output side_t side_out
);
  localparam int unsigned POS = 2 * (RW - 1 - STEP);
  logic [2*RW-1:0] radx;
  logic [1:0] pair;
  logic [RW+1:0] trial_rem;
  logic [RW+1:0] trial;
  logic fits;

  always_comb begin
    // radicand padded to whole bit pairs
    radx = (2*RW)'(rad_in);
    pair = radx[POS+1 -: 2];
    trial_rem = {rem_in[RW-1:0], pair};
    trial = {root_in, 2'b01};
    fits = trial_rem >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else if (en) vld_out <= vld_in;
    if (en) begin
      rad_out <= rad_in;
      side_out <= side_in;
      rem_out <= fits ? trial_rem - trial : trial_rem;
      root_out <= {root_in[RW-2:0], fits};
    end
  end
endmodule

@@ rtl/rmq_div_cell.sv @@
// module: one restoring divide step per cell for three lanes, registered
`timescale 1ns / 1ps
module rmq_div_cell import rmq_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vld_in,
  input  logic [RW:0] den_in,
  input  logic [RW-1:0] root_in,
  input  big_t big_in,
  input  dlane_t lane_in [3],
  output logic vld_out,
  output logic [RW:0] den_out,
  output logic [RW-1:0] root_out,
  output big_t big_out,
  output dlane_t lane_out [3]
);
  localparam int unsigned POS = NW - 1 - STEP;
  logic [RW+1:0] sh [3];
  logic ge [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {lane_in[i].rem[RW:0], lane_in[i].num[POS]};
      ge[i] = sh[i] >= {1'b0, den_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else if (en) vld_out <= vld_in;
    if (en) begin
      den_out <= den_in;
      root_out <= root_in;
      big_out <= big_in;
      for (int i = 0; i < 3; i++) begin
        lane_out[i].neg <= lane_in[i].neg;
        lane_out[i].num <= lane_in[i].num;
        lane_out[i].rem <= ge[i] ? sh[i] - {1'b0, den_in} : sh[i];
        lane_out[i].quo <= {lane_in[i].quo[QW-2:0], ge[i]};
      end
    end
  end
endmodule

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// top level: pipelined rotation matrix to quaternion conversion
// channels: s_axis carries one 3x3 rotation block per transfer, m_axis one
// quaternion per transfer. all values are signed Q2.16.
// flow: a front stage forms the trace, picks the large component (trace
// positive first, then strict diagonal compares, first match wins) and
// forms the root argument and the three off-diagonal sums or differences.
// a chain of root cells then yields one root bit per cell, and a chain of
// divide cells yields one quotient bit per cell for the three small
// components at once; a last stage rounds, saturates and orders them.
// path: the front register, the chain of root cells, the chain of divide
// cells and the output register, in that order.
// throughput: one transfer per cycle unless stalled; every cell moves its
// item on each cycle the pipeline advances.
// stall: the whole chain holds only while the output register is full and
// not being taken, and s_axis_tready drops in exactly that case.
// reset: rst clears the valid bits of every stage; data needs no reset.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up, zero padded
  input  logic [8*((9*DW+7)/8)-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // qx, qy, qz, qw from bit 0 up, zero padded
  output logic [8*((4*DW+7)/8)-1:0] m_axis_tdata
);
  localparam int unsigned D = DW;
  logic en;
  // every stage advances together; the output register is the only holder
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [D-1:0] r [9];
  always_comb begin
    for (int i = 0; i < 9; i++) r[i] = s_axis_tdata[i*D +: D];
  end

  // front stage
  logic signed [D+2:0] tr, ax, ay, az, one;
  logic signed [D+2:0] arg;
  side_t side_c;
  always_comb begin
    one = (D+3)'(64'sd1 <<< FRAC);
    tr = (D+3)'(r[0]) + (D+3)'(r[4]) + (D+3)'(r[8]);
    ax = one + (D+3)'(r[0]) - (D+3)'(r[4]) - (D+3)'(r[8]);
    ay = one + (D+3)'(r[4]) - (D+3)'(r[0]) - (D+3)'(r[8]);
    az = one + (D+3)'(r[8]) - (D+3)'(r[0]) - (D+3)'(r[4]);
    if (tr > 0) begin
      side_c.big = BIG_W;
      arg = one + tr;
      side_c.d0 = (D+1)'(r[7]) - (D+1)'(r[5]);
      side_c.d1 = (D+1)'(r[2]) - (D+1)'(r[6]);
      side_c.d2 = (D+1)'(r[3]) - (D+1)'(r[1]);
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      side_c.big = BIG_X;
      arg = ax;
      side_c.d0 = (D+1)'(r[7]) - (D+1)'(r[5]);
      side_c.d1 = (D+1)'(r[1]) + (D+1)'(r[3]);
      side_c.d2 = (D+1)'(r[2]) + (D+1)'(r[6]);
    end else if (r[4] > r[8]) begin
      side_c.big = BIG_Y;
      arg = ay;
      side_c.d0 = (D+1)'(r[2]) - (D+1)'(r[6]);
      side_c.d1 = (D+1)'(r[1]) + (D+1)'(r[3]);
      side_c.d2 = (D+1)'(r[5]) + (D+1)'(r[7]);
    end else begin
      side_c.big = BIG_Z;
      arg = az;
      side_c.d0 = (D+1)'(r[3]) - (D+1)'(r[1]);
      side_c.d1 = (D+1)'(r[2]) + (D+1)'(r[6]);
      side_c.d2 = (D+1)'(r[5]) + (D+1)'(r[7]);
    end
    if (arg < one) arg = one;
  end

  // root chain stage registers
  logic sv [NSQ+1];
  logic [SW-1:0] srad [NSQ+1];
  logic [RW+1:0] srem [NSQ+1];
  logic [RW-1:0] sroot [NSQ+1];
  side_t sside [NSQ+1];
  logic sv0;
  logic [SW-1:0] srad0;
  side_t sside0;

  always_ff @(posedge clk) begin
    if (rst) sv0 <= 1'b0;
    else if (en) sv0 <= s_axis_tvalid;
    if (en) begin
      srad0 <= SW'(arg[AW-1:0]) << FRAC;
      sside0 <= side_c;
    end
  end
  assign sv[0] = sv0;
  assign srad[0] = srad0;
  assign sside[0] = sside0;
  assign srem[0] = '0;
  assign sroot[0] = '0;

  // each cell holds its own registers while the chain is stalled
  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    logic v_o;
    logic [SW-1:0] rad_o;
    logic [RW+1:0] rem_o;
    logic [RW-1:0] root_o;
    side_t side_o;
    rmq_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(en), .vld_in(sv[g]),
      .rad_in(srad[g]),
      .rem_in(srem[g]),
      .root_in(sroot[g]),
      .side_in(sside[g]),
      .vld_out(v_o), .rad_out(rad_o), .rem_out(rem_o), .root_out(root_o),
      .side_out(side_o)
    );
    assign sv[g+1] = v_o;
    assign srad[g+1] = rad_o;
    assign srem[g+1] = rem_o;
    assign sroot[g+1] = root_o;
    assign sside[g+1] = side_o;
  end

  // divider set-up: divisor is twice the root, never zero
  logic [RW-1:0] rt;
  logic [RW:0] den0;
  always_comb begin
    rt = (sroot[NSQ] == '0) ? RW'(1) : sroot[NSQ];
    den0 = {rt, 1'b0};
  end

  logic dv [NDV+1];
  logic [RW:0] dden [NDV+1];
  logic [RW-1:0] droot [NDV+1];
  big_t dbig [NDV+1];
  dlane_t dl [NDV+1][3];
  logic signed [D:0] dsrc [3];

  assign dv[0] = sv[NSQ];
  assign dden[0] = den0;
  assign droot[0] = rt;
  assign dbig[0] = sside[NSQ].big;
  assign dsrc[0] = sside[NSQ].d0;
  assign dsrc[1] = sside[NSQ].d1;
  assign dsrc[2] = sside[NSQ].d2;
  for (genvar k = 0; k < 3; k++) begin : g_ld
    logic [D:0] mag;
    assign mag = dsrc[k][D] ? (D+1)'(-dsrc[k]) : dsrc[k];
    assign dl[0][k].neg = dsrc[k][D];
    assign dl[0][k].num = NW'(mag) << FRAC;
    assign dl[0][k].rem = '0;
    assign dl[0][k].quo = '0;
  end

  for (genvar g = 0; g < NDV; g++) begin : g_dv
    logic v_o;
    logic [RW:0] den_o;
    logic [RW-1:0] root_o;
    big_t big_o;
    dlane_t l_i [3];
    dlane_t l_o [3];
    for (genvar k = 0; k < 3; k++) begin : g_l
      assign l_i[k] = dl[g][k];
      assign dl[g+1][k] = l_o[k];
    end
    rmq_div_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(en), .vld_in(dv[g]),
      .den_in(dden[g]),
      .root_in(droot[g]),
      .big_in(dbig[g]), .lane_in(l_i),
      .vld_out(v_o), .den_out(den_o), .root_out(root_o), .big_out(big_o),
      .lane_out(l_o)
    );
    assign dv[g+1] = v_o;
    assign dden[g+1] = den_o;
    assign droot[g+1] = root_o;
    assign dbig[g+1] = big_o;
  end

  // final stage: round half up on magnitude, sign, saturate, reorder
  logic signed [QW+1:0] qs [3];
  logic signed [QW+1:0] half;
  logic signed [D-1:0] s0, s1, s2, sh;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [QW:0] qm;
      qm = {1'b0, dl[NDV][k].quo} +
           (QW+1)'({dl[NDV][k].rem[RW:0], 1'b0} >= {1'b0, dden[NDV]});
      qs[k] = dl[NDV][k].neg ? -(QW+2)'(qm) : (QW+2)'(qm);
    end
    half = (QW+2)'((RW+1)'(droot[NDV]) + (RW+1)'(1)) >>> 1;
    s0 = sat(qs[0]);
    s1 = sat(qs[1]);
    s2 = sat(qs[2]);
    sh = sat(half);
  end

  logic [4*D-1:0] q_c;
  always_comb begin
    case (dbig[NDV])
      BIG_W:   q_c = {sh, s2, s1, s0};
      BIG_X:   q_c = {s0, s2, s1, sh};
      BIG_Y:   q_c = {s0, s2, sh, s1};
      default: q_c = {s0, sh, s2, s1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= dv[NDV];
    if (en) m_axis_tdata <= $bits(m_axis_tdata)'(q_c);
  end

  // a stalled output holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
  // input ready follows the output register
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");
  // divisor never zero
  assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> dden[0] != '0)
    else $error("zero divisor");
endmodule

@@ tb/rmq_quat_checker.sv @@
// checker: watches both channels, predicts each quaternion and compares it
`timescale 1ns / 1ps
module rmq_quat_checker import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [167:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [71:0] m_tdata,
  output int fails,
  output int pending,
  output int n_checked
);
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint QMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint QMIN = -(64'sd1 <<< (DW - 1));

  logic [71:0] quat_q[$];

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // d * ONE / den, nearest, ties away from zero
  function automatic longint scaled_div(longint d, longint unsigned den);
    longint unsigned mag;
    longint unsigned qq;
    mag = longint'(d < 0 ? -d : d) << FRAC;
    qq = (mag + (den >> 1)) / den;
    return d < 0 ? -longint'(qq) : longint'(qq);
  endfunction

  function automatic logic [17:0] clamp(longint v);
    if (v > QMAX) v = QMAX;
    if (v < QMIN) v = QMIN;
    return v[17:0];
  endfunction

  function automatic logic [71:0] quat_of_matrix(logic [167:0] m);
    longint e[9];
    longint tr, a, d0, d1, d2, half, hx, hy, hz, hw;
    longint unsigned r;
    big_t big;
    for (int i = 0; i < 9; i++) e[i] = $signed(m[i*DW +: DW]);
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      big = BIG_W; a = ONE + tr;
      d0 = e[7] - e[5]; d1 = e[2] - e[6]; d2 = e[3] - e[1];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      big = BIG_X; a = ONE + e[0] - e[4] - e[8];
      d0 = e[7] - e[5]; d1 = e[1] + e[3]; d2 = e[2] + e[6];
    end else if (e[4] > e[8]) begin
      big = BIG_Y; a = ONE + e[4] - e[0] - e[8];
      d0 = e[2] - e[6]; d1 = e[1] + e[3]; d2 = e[5] + e[7];
    end else begin
      big = BIG_Z; a = ONE + e[8] - e[0] - e[4];
      d0 = e[3] - e[1]; d1 = e[2] + e[6]; d2 = e[5] + e[7];
    end
    r = int_root(longint'(a) << FRAC);
    half = longint'((r + 1) >> 1);
    case (big)
      BIG_W: begin
        hw = half; hx = scaled_div(d0, r << 1);
        hy = scaled_div(d1, r << 1); hz = scaled_div(d2, r << 1);
      end
      BIG_X: begin
        hx = half; hw = scaled_div(d0, r << 1);
        hy = scaled_div(d1, r << 1); hz = scaled_div(d2, r << 1);
      end
      BIG_Y: begin
        hy = half; hw = scaled_div(d0, r << 1);
        hx = scaled_div(d1, r << 1); hz = scaled_div(d2, r << 1);
      end
      default: begin
        hz = half; hw = scaled_div(d0, r << 1);
        hx = scaled_div(d1, r << 1); hy = scaled_div(d2, r << 1);
      end
    endcase
    return {clamp(hw), clamp(hz), clamp(hy), clamp(hx)};
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    n_checked = 0;
  end

  always @(posedge clk) begin
    logic [71:0] want;
    int nbad;
    nbad = 0;
    if (!rst) begin
      if (s_tvalid && s_tready) quat_q.push_back(quat_of_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        if (quat_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, m_tdata);
          nbad++;
        end else begin
          want = quat_q.pop_front();
          n_checked <= n_checked + 1;
          for (int f = 0; f < 4; f++)
            if (want[f*DW +: DW] !== m_tdata[f*DW +: DW]) begin
              $display("%0t: component %0d expected %h actual %h", $time, f,
                       want[f*DW +: DW], m_tdata[f*DW +: DW]);
              nbad++;
            end
        end
      end
      fails <= fails + nbad;
      pending <= quat_q.size();
    end
  end
endmodule

@@ tb/rotation_matrix_to_quaternion_unit_tb.sv @@
// testbench top: drives matrices and output stalls, gives the verdict
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_tb;
  localparam int ONE = 1 << 16;
  localparam int N_RAND = 1000;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [167:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;
  int fails, pending, n_checked;
  int idle_cnt = 0;
  int n_sent = 0;
  int rdy_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  rotation_matrix_to_quaternion_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  rmq_quat_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .pending(pending), .n_checked(n_checked)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls: alternating stretches of ready and not ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rdy_left == 0) begin
      if ($urandom_range(0, 9) < 2) begin
        m_tready <= 1'b1;
        rdy_left <= $urandom_range(50, 200);
      end else begin
        m_tready <= ~m_tready;
        rdy_left <= m_tready ? gap_len() : $urandom_range(1, 8);
      end
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [17:0] fx(int v);
    return v[17:0];
  endfunction

  function automatic logic [167:0] pack9(int m[9]);
    logic [167:0] t;
    t = '0;
    for (int i = 0; i < 9; i++) t[i*18 +: 18] = fx(m[i]);
    return t;
  endfunction

  // one matrix transfer, then a random gap
  task automatic send(input int m[9]);
    int g;
    s_tvalid <= 1'b1;
    s_tdata <= pack9(m);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic int rfield(int mode);
    case (mode)
      0: return int'($signed(18'($urandom)));
      1: return $urandom_range(0, 2 * ONE) - ONE;
      default: return $urandom_range(0, 64) - 32;
    endcase
  endfunction

  initial begin
    int m[9];
    int b, mode;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero, extremes, each large component, ties, saturation
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; send(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send(m);
    m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071}; send(m);
    m = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
          -131072}; send(m);
    m = '{131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072,
          131071}; send(m);
    m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send(m);
    m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; send(m);
    m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; send(m);
    m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, 0}; send(m);
    // diagonal ties fall through to the later branch
    m = '{0, 5, 7, 9, 0, 11, 13, 15, -ONE}; send(m);
    m = '{0, 5, 7, 9, -ONE, 11, 13, 15, 0}; send(m);
    m = '{-ONE, 5, 7, 9, 0, 11, 13, 15, 0}; send(m);
    m = '{-5, 3, 1, 2, -5, 4, 6, 8, -5}; send(m);
    // root of one with huge off-diagonal sums saturates
    m = '{0, 131071, 131071, 131071, 0, 131071, 131071, 131071, 0}; send(m);
    m = '{0, -131072, -131072, -131072, 0, -131072, -131072, -131072, 0}; send(m);
    m = '{1, -131072, 131071, 131071, 0, -131072, -131072, 131071, 0}; send(m);
    m = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071,
          -131072}; send(m);
    m = '{1, 1, 1, 1, 1, 1, 1, 1, -2}; send(m);

    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        // diagonal-led, to spread over the four branches
        for (int i = 0; i < 9; i++) m[i] = rfield(1);
        b = $urandom_range(0, 3);
        if (b < 3) m[b*4] = $urandom_range(ONE / 2, ONE);
        else begin m[0] = ONE - rfield(2); m[4] = ONE / 2; m[8] = ONE / 3; end
        if ($urandom_range(0, 7) == 0) m[$urandom_range(0, 2)*4] = m[b == 3 ? 0 : b*4];
      end else if (mode < 7) begin
        for (int i = 0; i < 9; i++) m[i] = rfield(0);
      end else begin
        for (int i = 0; i < 9; i++) m[i] = rfield($urandom_range(0, 2));
      end
      send(m);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("matrices sent: %0d, quaternions checked: %0d", n_sent, n_checked);
    $display("covered trace and diagonal branches, ties, extremes and saturation");
    if (fails == 0 && pending == 0) begin
      $display("rotation_matrix_to_quaternion_unit_tb OK");
    end else begin
      if (pending != 0) $display("%0t: %0d quaternions never arrived", $time, pending);
      $display("rotation_matrix_to_quaternion_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
